// ===== sv/fdr_pkg.sv =====
// Shared types and constants for the framed deviation receiver.
`timescale 1ns / 1ps

package fdr_pkg;

    // Frame storage limit and the widths that follow from it
    localparam int FRAME_BYTES = 7;
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);

    // Frame bytes and positions counted back from the end of the frame
    localparam logic [7:0] HDR_FIRST  = 8'h2C;
    localparam logic [7:0] HDR_SECOND = 8'h12;
    localparam logic [7:0] END_MARK   = 8'h5B;
    localparam int MIN_CLOSE_BYTES    = 6;
    localparam int DEV_BACK           = 5;
    localparam int FLAG_BACK          = 3;
    localparam int HIST_DEPTH         = DEV_BACK;

    // Configuration register reset values and addressing
    localparam logic [7:0] OFFSET_RESET = 8'd100;
    localparam logic [7:0] LIMIT_RESET  = 8'd90;
    localparam int ADDR_W               = 3;

    typedef enum logic
    {
        REG_CENTER_OFFSET   = 1'b0,
        REG_DEVIATION_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        HUNT_FIRST   = 2'd0,
        HUNT_SECOND  = 2'd1,
        HUNT_STORE   = 2'd2,
        HUNT_SWALLOW = 2'd3
    } hunt_state_t;

    // Frame close event from the parser
    typedef struct packed
    {
        logic       close;
        logic [7:0] dev_byte;
        logic [7:0] flag_byte;
    } frame_evt_t;

    // One result item
    typedef struct packed
    {
        logic signed [8:0] deviation;
        logic [7:0]        flag_value;
        logic              deviation_held;
    } result_t;

endpackage

// ===== sv/fdr_parser.sv =====
// Frame hunter: header match, byte storage and frame close detection.
`timescale 1ns / 1ps

module fdr_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_transfer,
    input  logic [7:0]          rx_byte,
    output fdr_pkg::frame_evt_t evt
);

    fdr_pkg::hunt_state_t               state_reg;
    fdr_pkg::hunt_state_t               state_next;
    logic [fdr_pkg::COUNT_W-1:0]        count_reg;
    logic [fdr_pkg::COUNT_W-1:0]        count_next;
    logic [7:0]                         hist_reg [fdr_pkg::HIST_DEPTH];
    logic                               store;

    // State and byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdr_pkg::HUNT_FIRST;
            count_reg <= '0;
        end
        else if (byte_transfer)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Next state, storage and close event
    always_comb
    begin
        state_next    = fdr_pkg::HUNT_FIRST;
        count_next    = '0;
        store         = 1'b0;
        evt.close     = 1'b0;
        evt.dev_byte  = hist_reg[fdr_pkg::DEV_BACK - 1];
        evt.flag_byte = hist_reg[fdr_pkg::FLAG_BACK - 1];
        unique case (state_reg)
            fdr_pkg::HUNT_FIRST:
            begin
                if (rx_byte == fdr_pkg::HDR_FIRST)
                begin
                    store      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = fdr_pkg::HUNT_SECOND;
                end
            end
            fdr_pkg::HUNT_SECOND:
            begin
                if (rx_byte == fdr_pkg::HDR_SECOND)
                begin
                    store      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = fdr_pkg::HUNT_STORE;
                end
            end
            fdr_pkg::HUNT_STORE:
            begin
                count_next = count_reg;
                state_next = fdr_pkg::HUNT_STORE;
                if (count_reg < fdr_pkg::COUNT_W'(fdr_pkg::FRAME_BYTES))
                begin
                    store      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                if (count_next >= fdr_pkg::COUNT_W'(fdr_pkg::FRAME_BYTES) ||
                    rx_byte == fdr_pkg::END_MARK)
                begin
                    state_next = fdr_pkg::HUNT_SWALLOW;
                end
            end
            fdr_pkg::HUNT_SWALLOW:
            begin
                // Close only on a marker and with enough bytes to look back into
                evt.close = (hist_reg[0] == fdr_pkg::END_MARK) &&
                            (count_reg >= fdr_pkg::COUNT_W'(fdr_pkg::MIN_CLOSE_BYTES));
            end
            default:
            begin
                state_next = fdr_pkg::HUNT_FIRST;
            end
        endcase
    end

    // Shift stored bytes through the look-back line
    always_ff @(posedge clk)
    begin
        if (byte_transfer && store)
        begin
            hist_reg[0] <= rx_byte;
            for (int i = 1; i < fdr_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

endmodule

// ===== sv/framed_deviation_receiver_core.sv =====
// Top level: configuration port, deviation filter and result queue.
// A closing byte transfer registers its result in the output register or skid entry.
// One byte per cycle unless the skid is full; parser and filter update in one pass.
// A two-entry result queue keeps bytes flowing while a result waits to be taken.
// Reset (rst_n low, asynchronous) restarts the hunt, clears the last good deviation,
// empties the queue and loads offset 100 and limit 90.
`timescale 1ns / 1ps

module framed_deviation_receiver_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fdr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Byte input
    input  logic                       rx_valid,
    output logic                       rx_ready,
    input  logic [7:0]                 rx_byte,
    // Result output
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic signed [8:0]          deviation,
    output logic [7:0]                 flag_value,
    output logic                       deviation_held
);

    logic [7:0]          offset_reg;
    logic [7:0]          limit_reg;
    logic signed [8:0]   last_good_reg;
    fdr_pkg::reg_index_t reg_sel;
    logic                cfg_write;
    logic                rx_transfer;
    logic                res_transfer;
    fdr_pkg::frame_evt_t evt;
    logic signed [9:0]   dev_raw;
    logic signed [9:0]   lim_pos;
    logic                out_of_range;
    fdr_pkg::result_t    res_new;
    fdr_pkg::result_t    out_reg;
    fdr_pkg::result_t    skid_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;
    logic                push;

    // Configuration writes and reads
    assign pready    = 1'b1;
    assign reg_sel   = fdr_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= fdr_pkg::OFFSET_RESET;
            limit_reg  <= fdr_pkg::LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                fdr_pkg::REG_CENTER_OFFSET:   offset_reg <= pwdata[7:0];
                fdr_pkg::REG_DEVIATION_LIMIT: limit_reg  <= pwdata[7:0];
                default:                      offset_reg <= offset_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            fdr_pkg::REG_CENTER_OFFSET:   prdata = {24'd0, offset_reg};
            fdr_pkg::REG_DEVIATION_LIMIT: prdata = {24'd0, limit_reg};
            default:                      prdata = '0;
        endcase
    end

    // Handshakes
    assign rx_ready     = !skid_valid_reg;
    assign rx_transfer  = rx_valid && rx_ready;
    assign res_transfer = out_valid_reg && res_ready;

    fdr_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_transfer (rx_transfer),
        .rx_byte       (rx_byte),
        .evt           (evt)
    );

    // Form the deviation and hold the last good one when out of range
    assign dev_raw      = $signed({2'b00, evt.dev_byte}) - $signed({2'b00, offset_reg});
    assign lim_pos      = $signed({2'b00, limit_reg});
    assign out_of_range = (dev_raw < -lim_pos) || (dev_raw > lim_pos);

    always_comb
    begin
        res_new.flag_value     = evt.flag_byte;
        res_new.deviation_held = out_of_range;
        res_new.deviation      = out_of_range ? last_good_reg : dev_raw[8:0];
    end

    assign push = rx_transfer && evt.close;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_good_reg <= '0;
        end
        else if (push && !out_of_range)
        begin
            last_good_reg <= dev_raw[8:0];
        end
    end

    // Result queue: output register backed by one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (res_transfer)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_transfer)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_new;
        end
        else if (push && !out_valid_reg)
        begin
            out_reg <= res_new;
        end
        if (push && out_valid_reg && !res_transfer)
        begin
            skid_reg <= res_new;
        end
    end

    assign res_valid      = out_valid_reg;
    assign deviation      = out_reg.deviation;
    assign flag_value     = out_reg.flag_value;
    assign deviation_held = out_reg.deviation_held;

endmodule
